// ===== hdl/pktbl_pkg.sv =====
// Shared types and constants for the per-key token bucket limiter.
// No dependencies.
package pktbl_pkg;

    localparam int TOK_W   = 40;            // tokens in millionths
    localparam int MUL_W   = 20;            // shared multiplier operand width
    localparam int ACC_W   = 2 * MUL_W + MUL_W;
    localparam int RATE_W  = 20;
    localparam int BURST_W = 16;
    localparam int INFL_W  = 16;
    localparam int LIM_W   = 7;

    localparam logic [MUL_W-1:0]  TOKEN_UNIT_M = 20'd1000000;
    localparam logic [TOK_W-1:0]  TOKEN_UNIT   = 40'd1000000;
    localparam logic [INFL_W-1:0] INFL_MAX     = 16'hFFFF;
    localparam logic [LIM_W-1:0]  LIM_RESET    = 7'd64;

    typedef enum logic [2:0] {
        ST_ADMIT_TRACKED   = 3'd0,
        ST_ADMIT_UNTRACKED = 3'd1,
        ST_NO_TOKEN        = 3'd2,
        ST_INFLIGHT_CAP    = 3'd3,
        ST_TABLE_FULL      = 3'd4,
        ST_RELEASED        = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_RATE  = 2'd0,
        REG_BURST = 2'd1,
        REG_CAP   = 2'd2,
        REG_LIMIT = 2'd3
    } reg_idx_t;

endpackage

// ===== hdl/pktbl_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pktbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/per_key_token_bucket_limiter.sv =====
// Per-key token bucket limiter: top level, sequencer and configuration port.
// Depends on pktbl_pkg and pktbl_ram (one entry per word, swept one a cycle).
// Throughput: one item at a time, busy high meanwhile; results cannot be stalled.
// Reset (async, active low) clears valid bits, key count, rate, burst and cap;
// it sets the limit register to 64; RAM is not reset.
module per_key_token_bucket_limiter
    import pktbl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int KEY_BITS      = 32,
    parameter int TIME_BITS     = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // command side
    input  logic                  start,
    output logic                  busy,
    input  logic                  kind,
    input  logic [KEY_BITS-1:0]   client_key,
    input  logic [TIME_BITS-1:0]  now_us,
    input  logic [5:0]            release_slot,
    // result side
    output logic                  done,
    output logic [2:0]            status,
    output logic [5:0]            slot,
    output logic [6:0]            tracked_count,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CW    = (CNT_W > LIM_W) ? CNT_W : LIM_W;
    localparam int DW    = (TIME_BITS > TOK_W) ? TIME_BITS : TOK_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [TOK_W-1:0]     tokens;
        logic [TIME_BITS-1:0] last;
        logic [INFL_W-1:0]    inflight;
        logic [IDX_W-1:0]     rank;
    } ent_t;

    localparam int EW = $bits(ent_t);

    typedef enum logic [4:0] {
        S_IDLE, S_REL, S_CAP, S_CAPW, S_LOOK, S_LKEND, S_EVCHK, S_VSCAN, S_VSEND,
        S_REMOVE, S_INSCHK, S_INC, S_INSEND, S_PROMO, S_REF0, S_REF1, S_REF2,
        S_REF3, S_REF4, S_REF5, S_GRANT
    } state_t;

    // configuration registers
    logic [RATE_W-1:0]  rate_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [INFL_W-1:0]  icap_reg;
    logic [LIM_W-1:0]   limit_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    // sequencer state
    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         ptr_reg, pd_reg;
    logic                     iss_reg, dv_reg, sweep_go, sweep_done;
    logic [IDX_W-1:0]         s_reg, s_next;
    logic                     found_reg, found_next;
    logic [IDX_W-1:0]         rrank_reg, rrank_next;
    logic [IDX_W-1:0]         vic_reg, vic_next;
    logic                     vfound_reg, vfound_next;
    logic [IDX_W-1:0]         vrank_reg, vrank_next;
    logic [IDX_W-1:0]         free_reg, free_next;
    logic                     ffound_reg, ffound_next;
    ent_t                     ent_reg, ent_next, rd_ent, wr_ent;
    logic [KEY_BITS-1:0]      key_reg, key_next;
    logic [TIME_BITS-1:0]     now_reg, now_next;
    logic                     rsok_reg, rsok_next;
    logic [TOK_W-1:0]         cap_reg, cap_next;
    logic [TIME_BITS-1:0]     dt_reg, dt_next;
    logic [DW-1:0]            dt_ext;
    logic [TOK_W-1:0]         room_reg, room_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [2*MUL_W-1:0]       mul_reg;
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic                     mul_en;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     done_reg, done_next;
    status_t                  status_reg, status_next;
    logic [5:0]               slot_reg, slot_next;

    // RAM port
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr, ram_raddr;
    logic [EW-1:0]            ram_rdata;

    // eviction threshold, zero acts as one
    logic [CW-1:0]            lim_cmp, cnt_cmp;
    logic                     no_tok, at_cap;

    pktbl_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_ent),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_ent     = ent_t'(ram_rdata);
    assign sweep_done = dv_reg && (pd_reg == LAST_IDX);
    assign dt_ext     = DW'(dt_reg);
    assign lim_cmp    = (limit_reg == '0) ? CW'(1) : CW'(limit_reg);
    assign cnt_cmp    = CW'(count_reg);
    assign no_tok     = (rate_reg != '0) && (ent_reg.tokens < TOKEN_UNIT);
    assign at_cap     = (icap_reg != '0) && (ent_reg.inflight >= icap_reg);

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign slot          = slot_reg;
    assign tracked_count = 7'(count_reg);

    // APB: always ready, write on access phase
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_idx)
            REG_RATE:  prdata = 32'(rate_reg);
            REG_BURST: prdata = 32'(burst_reg);
            REG_CAP:   prdata = 32'(icap_reg);
            REG_LIMIT: prdata = 32'(limit_reg);
            default:   prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        s_next      = s_reg;
        found_next  = found_reg;
        rrank_next  = rrank_reg;
        vic_next    = vic_reg;
        vfound_next = vfound_reg;
        vrank_next  = vrank_reg;
        free_next   = free_reg;
        ffound_next = ffound_reg;
        ent_next    = ent_reg;
        key_next    = key_reg;
        now_next    = now_reg;
        rsok_next   = rsok_reg;
        cap_next    = cap_reg;
        dt_next     = dt_reg;
        room_next   = room_reg;
        acc_next    = acc_reg;
        valid_next  = valid_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;
        sweep_go    = 1'b0;
        mul_en      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        ram_we      = 1'b0;
        ram_waddr   = pd_reg;
        ram_raddr   = ptr_reg;
        wr_ent      = rd_ent;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next = client_key;
                    now_next = now_us;
                    if (kind)
                    begin
                        s_next     = IDX_W'(release_slot);
                        rsok_next  = (32'(release_slot) < TABLE_ENTRIES);
                        ram_raddr  = IDX_W'(release_slot);
                        state_next = S_REL;
                    end
                    else if (((rate_reg == '0) && (icap_reg == '0)) || (client_key == '0))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_ADMIT_UNTRACKED;
                        slot_next   = '0;
                    end
                    else
                    begin
                        state_next = S_CAP;
                    end
                end
            end

            S_REL:
            begin
                if (rsok_reg && valid_reg[s_reg] && (rd_ent.inflight != '0))
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = s_reg;
                    wr_ent.inflight = rd_ent.inflight - 1'b1;
                end
                done_next   = 1'b1;
                status_next = ST_RELEASED;
                slot_next   = '0;
                state_next  = S_IDLE;
            end

            // capacity = (burst or rate) * one token, on the shared multiplier
            S_CAP:
            begin
                mul_en     = 1'b1;
                mul_a      = (burst_reg != '0) ? MUL_W'(burst_reg) : MUL_W'(rate_reg);
                mul_b      = TOKEN_UNIT_M;
                state_next = S_CAPW;
            end

            S_CAPW:
            begin
                cap_next   = TOK_W'(mul_reg);
                found_next = 1'b0;
                sweep_go   = 1'b1;
                state_next = S_LOOK;
            end

            S_LOOK:
            begin
                if (dv_reg && !found_reg && valid_reg[pd_reg] && (rd_ent.key == key_reg))
                begin
                    found_next = 1'b1;
                    s_next     = pd_reg;
                    ent_next   = rd_ent;
                end
                if (sweep_done)
                begin
                    state_next = S_LKEND;
                end
            end

            S_LKEND:
            begin
                if (found_reg)
                begin
                    rrank_next = ent_reg.rank;
                    sweep_go   = 1'b1;
                    state_next = S_PROMO;
                end
                else
                begin
                    state_next = S_EVCHK;
                end
            end

            S_EVCHK:
            begin
                if ((cnt_cmp >= lim_cmp) && (count_reg != '0))
                begin
                    vfound_next = 1'b0;
                    sweep_go    = 1'b1;
                    state_next  = S_VSCAN;
                end
                else
                begin
                    state_next = S_INSCHK;
                end
            end

            // least recent idle key has the highest rank
            S_VSCAN:
            begin
                if (dv_reg && valid_reg[pd_reg] && (rd_ent.inflight == '0) &&
                    (!vfound_reg || (rd_ent.rank > vrank_reg)))
                begin
                    vfound_next = 1'b1;
                    vic_next    = pd_reg;
                    vrank_next  = rd_ent.rank;
                end
                if (sweep_done)
                begin
                    state_next = S_VSEND;
                end
            end

            S_VSEND:
            begin
                if (vfound_reg)
                begin
                    sweep_go   = 1'b1;
                    state_next = S_REMOVE;
                end
                else
                begin
                    state_next = S_INSCHK;
                end
            end

            S_REMOVE:
            begin
                if (dv_reg && valid_reg[pd_reg] && (pd_reg != vic_reg) &&
                    (rd_ent.rank > vrank_reg))
                begin
                    ram_we      = 1'b1;
                    wr_ent.rank = rd_ent.rank - 1'b1;
                end
                if (sweep_done)
                begin
                    valid_next[vic_reg] = 1'b0;
                    count_next          = count_reg - 1'b1;
                    state_next          = S_EVCHK;
                end
            end

            S_INSCHK:
            begin
                if (count_reg == FULL_CNT)
                begin
                    done_next   = 1'b1;
                    status_next = ST_TABLE_FULL;
                    slot_next   = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ffound_next = 1'b0;
                    sweep_go    = 1'b1;
                    state_next  = S_INC;
                end
            end

            // age every held key, find the lowest free slot
            S_INC:
            begin
                if (dv_reg)
                begin
                    if (valid_reg[pd_reg])
                    begin
                        ram_we      = 1'b1;
                        wr_ent.rank = rd_ent.rank + 1'b1;
                    end
                    else if (!ffound_reg)
                    begin
                        ffound_next = 1'b1;
                        free_next   = pd_reg;
                    end
                end
                if (sweep_done)
                begin
                    state_next = S_INSEND;
                end
            end

            S_INSEND:
            begin
                s_next               = free_reg;
                valid_next[free_reg] = 1'b1;
                count_next           = count_reg + 1'b1;
                ent_next.key         = key_reg;
                ent_next.tokens      = cap_reg;
                ent_next.last        = now_reg;
                ent_next.inflight    = '0;
                ent_next.rank        = '0;
                state_next           = S_REF0;
            end

            S_PROMO:
            begin
                if (dv_reg && valid_reg[pd_reg] && (pd_reg != s_reg) &&
                    (rd_ent.rank < rrank_reg))
                begin
                    ram_we      = 1'b1;
                    wr_ent.rank = rd_ent.rank + 1'b1;
                end
                if (sweep_done)
                begin
                    state_next = S_REF0;
                end
            end

            // refill: cap when dt*rate exceeds the room left, else add it
            S_REF0:
            begin
                dt_next = now_reg - ent_reg.last;
                if ((rate_reg != '0) && (now_reg > ent_reg.last))
                begin
                    state_next = S_REF1;
                end
                else
                begin
                    state_next = S_GRANT;
                end
            end

            S_REF1:
            begin
                if (ent_reg.tokens >= cap_reg)
                begin
                    ent_next.tokens = cap_reg;
                    ent_next.last   = now_reg;
                    state_next      = S_GRANT;
                end
                else
                begin
                    room_next  = cap_reg - ent_reg.tokens;
                    state_next = S_REF2;
                end
            end

            // rate >= 1, so dt above the room saturates without a product
            S_REF2:
            begin
                if (dt_ext > DW'(room_reg))
                begin
                    ent_next.tokens = cap_reg;
                    ent_next.last   = now_reg;
                    state_next      = S_GRANT;
                end
                else
                begin
                    mul_en     = 1'b1;
                    mul_a      = dt_ext[MUL_W-1:0];
                    mul_b      = MUL_W'(rate_reg);
                    state_next = S_REF3;
                end
            end

            S_REF3:
            begin
                acc_next   = ACC_W'(mul_reg);
                mul_en     = 1'b1;
                mul_a      = dt_ext[2*MUL_W-1:MUL_W];
                mul_b      = MUL_W'(rate_reg);
                state_next = S_REF4;
            end

            S_REF4:
            begin
                acc_next   = acc_reg + {mul_reg, {MUL_W{1'b0}}};
                state_next = S_REF5;
            end

            S_REF5:
            begin
                if (acc_reg > ACC_W'(room_reg))
                begin
                    ent_next.tokens = cap_reg;
                end
                else
                begin
                    ent_next.tokens = ent_reg.tokens + acc_reg[TOK_W-1:0];
                end
                ent_next.last = now_reg;
                state_next    = S_GRANT;
            end

            S_GRANT:
            begin
                wr_ent      = ent_reg;
                wr_ent.rank = '0;
                slot_next   = '0;
                if (no_tok)
                begin
                    status_next = ST_NO_TOKEN;
                end
                else if (at_cap)
                begin
                    status_next = ST_INFLIGHT_CAP;
                end
                else
                begin
                    if (rate_reg != '0)
                    begin
                        wr_ent.tokens = ent_reg.tokens - TOKEN_UNIT;
                    end
                    if (ent_reg.inflight != INFL_MAX)
                    begin
                        wr_ent.inflight = ent_reg.inflight + 1'b1;
                    end
                    status_next = ST_ADMIT_TRACKED;
                    slot_next   = 6'(s_reg);
                end
                ram_we     = 1'b1;
                ram_waddr  = s_reg;
                ent_next   = wr_ent;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            iss_reg    <= 1'b0;
            dv_reg     <= 1'b0;
            ptr_reg    <= '0;
            pd_reg     <= '0;
            valid_reg  <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_ADMIT_TRACKED;
            slot_reg   <= '0;
            rate_reg   <= '0;
            burst_reg  <= '0;
            icap_reg   <= '0;
            limit_reg  <= LIM_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            slot_reg   <= slot_next;

            // sweep pointer: read issued at ptr, data back in the following cycle at pd
            if (sweep_go)
            begin
                ptr_reg <= '0;
                iss_reg <= 1'b1;
            end
            else if (iss_reg)
            begin
                ptr_reg <= ptr_reg + 1'b1;
                iss_reg <= (ptr_reg != LAST_IDX);
            end
            dv_reg <= iss_reg;
            pd_reg <= ptr_reg;

            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_RATE:  rate_reg  <= pwdata[RATE_W-1:0];
                    REG_BURST: burst_reg <= pwdata[BURST_W-1:0];
                    REG_CAP:   icap_reg  <= pwdata[INFL_W-1:0];
                    REG_LIMIT: limit_reg <= pwdata[LIM_W-1:0];
                    default:   limit_reg <= limit_reg;
                endcase
            end
        end
    end

    // working payload, no reset needed
    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        found_reg  <= found_next;
        rrank_reg  <= rrank_next;
        vic_reg    <= vic_next;
        vfound_reg <= vfound_next;
        vrank_reg  <= vrank_next;
        free_reg   <= free_next;
        ffound_reg <= ffound_next;
        ent_reg    <= ent_next;
        key_reg    <= key_next;
        now_reg    <= now_next;
        rsok_reg   <= rsok_next;
        cap_reg    <= cap_next;
        dt_reg     <= dt_next;
        room_reg   <= room_next;
        acc_reg    <= acc_next;
        if (mul_en)
        begin
            mul_reg <= mul_a * mul_b;
        end
    end

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(count_reg))
        else $error("key count differs from valid bits");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("key count above table size");

    // a result is only ever presented once the sequencer is back at idle
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while sequencer busy");

    a_sweep_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !iss_reg)
        else $error("table pass running while idle");
`endif

endmodule
